### hdl/bbc_pkg.sv
// Shared constants and types for the Bollinger band calculator.
// Used by bollinger_band_calculator_core and the testbench; depends on nothing else.
package bbc_pkg;

    localparam int MAX_WINDOW_DEF = 64;
    localparam int PRICE_W        = 32;
    localparam int TIME_W         = 63;
    localparam int CFG_W          = 7;
    localparam int WIN_MIN        = 2;
    localparam logic [CFG_W-1:0] WLEN_RESET = 7'd20;

    typedef enum logic [3:0] {
        ST_IDLE,
        ST_RD_ADDR,
        ST_RD_MUL,
        ST_RD_ACC,
        ST_MUL_NQ,
        ST_MUL_SS,
        ST_DIV_MEAN,
        ST_DIV_VAR,
        ST_SQRT,
        ST_OUT
    } t_state;

endpackage

### hdl/bbc_ram.sv
// Generic single-write, single-read RAM with registered read data.
// Standalone; no package dependency.
module bbc_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 64
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule

### hdl/bbc_div.sv
// Restoring divider, one quotient bit per cycle, shared for mean and variance.
// Standalone; no package dependency.
module bbc_div #(
    parameter int NUMW = 78,
    parameter int DENW = 14
) (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  logic            i_start,
    input  logic [NUMW-1:0] i_num,
    input  logic [DENW-1:0] i_den,
    output logic            o_done,
    output logic [NUMW-1:0] o_quo
);

    localparam int CNTW = $clog2(NUMW + 1);

    logic [DENW-1:0] r_rem, n_rem;
    logic [NUMW-1:0] r_quo, n_quo;
    logic [DENW-1:0] r_den;
    logic [CNTW-1:0] r_cnt;
    logic            r_done;
    logic [DENW:0]   trial;
    logic            ge;

    always_comb begin
        trial = {r_rem, r_quo[NUMW-1]};
        ge    = (trial >= {1'b0, r_den});
        n_rem = ge ? DENW'(trial - {1'b0, r_den}) : trial[DENW-1:0];
        n_quo = {r_quo[NUMW-2:0], ge};
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cnt  <= '0;
            r_done <= 1'b0;
        end else begin
            r_done <= 1'b0;
            if (i_start) begin
                r_cnt <= CNTW'(NUMW);
            end else if (r_cnt != '0) begin
                r_cnt <= r_cnt - 1'b1;
                if (r_cnt == CNTW'(1)) begin
                    r_done <= 1'b1;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_rem <= '0;
            r_quo <= i_num;
            r_den <= i_den;
        end else if (r_cnt != '0) begin
            r_rem <= n_rem;
            r_quo <= n_quo;
        end
    end

    assign o_done = r_done;
    assign o_quo  = r_quo;

endmodule

### hdl/bollinger_band_calculator_core.sv
// Bollinger band calculator: sliding window mean and two-sigma bands.
// Depends on bbc_pkg, bbc_ram and bbc_div.
//
// Usage:
//   Input channel s_axis carries one closing price (Q16.16) and its 63-bit
//   timestamp per transaction. Output channel m_axis carries the mean, the
//   upper and lower bands and the timestamp of the newest bar.
//   i_cfg_we / i_cfg_wdata write the window length N (clamped to 2..MAX_WINDOW).
//   Until N prices are stored an input produces no output.
// Sequencing:
//   A stored-only item is written to the window RAM and starts no computation. A full
//   item runs a sequencer: per window entry a RAM read, a 32x32 square and an
//   accumulate; then two bit-serial multiplies, two passes of the shared serial
//   divider and 32 square-root steps. The next input is taken only after the result
//   is loaded. s_axis_tready is high only while the sequencer is idle.
// Reset and stalls:
//   Reset empties the window, sets N to 20 and drops any pending output. A
//   result waits in the output register while m_axis_tready is low; the next
//   item is accepted meanwhile, but its result waits until the register frees.
module bollinger_band_calculator_core #(
    parameter int MAX_WINDOW = bbc_pkg::MAX_WINDOW_DEF
) (
    input  logic                      i_clk,
    input  logic                      i_rst_n,
    input  logic                      i_cfg_we,
    input  logic [bbc_pkg::CFG_W-1:0] i_cfg_wdata,
    input  logic                      s_axis_tvalid,
    output logic                      s_axis_tready,
    // close_price[31:0], bar_time[94:32], zero pad[95]
    input  logic [95:0]               s_axis_tdata,
    output logic                      m_axis_tvalid,
    input  logic                      m_axis_tready,
    // middle_band[31:0], upper_band[63:32], lower_band[95:64],
    // result_time[158:96], zero pad[159]
    output logic [159:0]              m_axis_tdata
);

    import bbc_pkg::*;

    localparam int AW   = $clog2(MAX_WINDOW);
    localparam int NW   = $clog2(MAX_WINDOW + 1);
    localparam int SW   = PRICE_W + NW;
    localparam int QW   = 2 * PRICE_W + NW;
    localparam int VW   = 2 * PRICE_W + 2 * NW;
    localparam int DW   = 2 * NW;
    localparam int CW   = (NW > CFG_W) ? NW : CFG_W;
    localparam int MCW  = $clog2(SW + 1);
    localparam int SCW  = $clog2(PRICE_W + 1);
    localparam int VARW = 2 * PRICE_W;

    t_state r_state, n_state;

    logic [CFG_W-1:0]   r_wlen;
    logic [AW-1:0]      r_wp;
    logic [AW-1:0]      r_rp;
    logic [NW-1:0]      r_fill;
    logic [NW-1:0]      r_n;
    logic [NW-1:0]      r_idx;
    logic [DW-1:0]      r_den;
    logic [TIME_W-1:0]  r_time;
    logic [SW-1:0]      r_sum;
    logic [QW-1:0]      r_sq;
    logic [VARW-1:0]    r_prod;
    logic [VW-1:0]      r_acc;
    logic [VW-1:0]      r_nq;
    logic [SW-1:0]      r_mplier;
    logic [MCW-1:0]     r_mcnt;
    logic [PRICE_W-1:0] r_mean;
    logic [VARW-1:0]    r_var;
    logic [PRICE_W:0]   r_rem;
    logic [PRICE_W-1:0] r_root;
    logic [SCW-1:0]     r_scnt;
    logic               r_out_valid;
    logic [159:0]       r_out_data;

    logic               in_acc;
    logic [CW-1:0]      cfg_w;
    logic [NW-1:0]      n_eff;
    logic [NW-1:0]      fill_inc;
    logic [PRICE_W-1:0] ram_rdata;
    logic [VW-1:0]      mcand;
    logic [VW-1:0]      mul_next;
    logic               mul_last;
    logic               div_start;
    logic [VW-1:0]      div_num;
    logic [DW-1:0]      div_den;
    logic               div_done;
    logic [VW-1:0]      div_quo;
    logic [PRICE_W+2:0] rem_sh;
    logic [PRICE_W+2:0] trial;
    logic               sq_ge;
    logic [PRICE_W:0]   two_sig;
    logic [PRICE_W+1:0] upper_sum;
    logic [PRICE_W-1:0] upper_band;
    logic [PRICE_W-1:0] lower_band;
    logic               out_load;

    bbc_ram #(.WIDTH(PRICE_W), .DEPTH(MAX_WINDOW)) u_ram (
        .i_clk   (i_clk),
        .i_we    (in_acc),
        .i_waddr (r_wp),
        .i_wdata (s_axis_tdata[PRICE_W-1:0]),
        .i_raddr (r_rp),
        .o_rdata (ram_rdata)
    );

    bbc_div #(.NUMW(VW), .DENW(DW)) u_div (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (div_start),
        .i_num   (div_num),
        .i_den   (div_den),
        .o_done  (div_done),
        .o_quo   (div_quo)
    );

    // Effective window length and fill level after this item.
    always_comb begin
        cfg_w = CW'(r_wlen);
        if (cfg_w < CW'(WIN_MIN)) begin
            n_eff = NW'(WIN_MIN);
        end else if (cfg_w > CW'(MAX_WINDOW)) begin
            n_eff = NW'(MAX_WINDOW);
        end else begin
            n_eff = NW'(cfg_w);
        end
        fill_inc = (r_fill == NW'(MAX_WINDOW)) ? r_fill : r_fill + 1'b1;
    end

    // Shared shift-add multiplier step; N*Q first, then S*S.
    always_comb begin
        mcand    = (r_state == ST_MUL_NQ) ? VW'(r_sq) : VW'(r_sum);
        mul_next = {r_acc[VW-2:0], 1'b0} + (r_mplier[SW-1] ? mcand : '0);
        mul_last = (r_mcnt == MCW'(1));
    end

    // Square root digit step.
    always_comb begin
        rem_sh = {r_rem, r_var[VARW-1 -: 2]};
        trial  = {1'b0, r_root, 2'b01};
        sq_ge  = (rem_sh >= trial);
    end

    always_comb begin
        two_sig    = {r_root, 1'b0};
        upper_sum  = (PRICE_W+2)'(r_mean) + (PRICE_W+2)'(two_sig);
        upper_band = (upper_sum > (PRICE_W+2)'({PRICE_W{1'b1}})) ? {PRICE_W{1'b1}}
                                                               : upper_sum[PRICE_W-1:0];
        lower_band = (two_sig >= (PRICE_W+1)'(r_mean)) ? '0
                                                      : PRICE_W'((PRICE_W+1)'(r_mean) - two_sig);
    end

    // Next state.
    always_comb begin
        n_state = r_state;
        case (r_state)
            ST_IDLE: begin
                if (in_acc && (fill_inc >= n_eff)) begin
                    n_state = ST_RD_ADDR;
                end
            end
            ST_RD_ADDR: n_state = ST_RD_MUL;
            ST_RD_MUL:  n_state = ST_RD_ACC;
            ST_RD_ACC: begin
                n_state = (r_idx == NW'(1)) ? ST_MUL_NQ : ST_RD_ADDR;
            end
            ST_MUL_NQ: begin
                if (mul_last) begin
                    n_state = ST_MUL_SS;
                end
            end
            ST_MUL_SS: begin
                if (mul_last) begin
                    n_state = ST_DIV_MEAN;
                end
            end
            ST_DIV_MEAN: begin
                if (div_done) begin
                    n_state = ST_DIV_VAR;
                end
            end
            ST_DIV_VAR: begin
                if (div_done) begin
                    n_state = ST_SQRT;
                end
            end
            ST_SQRT: begin
                if (r_scnt == SCW'(1)) begin
                    n_state = ST_OUT;
                end
            end
            ST_OUT: begin
                if (out_load) begin
                    n_state = ST_IDLE;
                end
            end
            default: n_state = ST_IDLE;
        endcase
    end

    // Control outputs.
    always_comb begin
        s_axis_tready = 1'b0;
        div_start     = 1'b0;
        div_num       = r_nq - r_acc;
        div_den       = r_den;
        out_load      = 1'b0;
        case (r_state)
            ST_IDLE:     s_axis_tready = 1'b1;
            ST_MUL_SS: begin
                div_start = mul_last;
                div_num   = VW'(r_sum + SW'(r_n >> 1));
                div_den   = DW'(r_n);
            end
            ST_DIV_MEAN: div_start = div_done;
            ST_OUT:      out_load  = !r_out_valid || m_axis_tready;
            default: begin
                s_axis_tready = 1'b0;
            end
        endcase
    end

    assign in_acc = s_axis_tvalid && s_axis_tready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= ST_IDLE;
            r_wlen      <= WLEN_RESET;
            r_wp        <= '0;
            r_fill      <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_state <= n_state;
            if (i_cfg_we) begin
                r_wlen <= i_cfg_wdata;
            end
            if (in_acc) begin
                r_wp   <= (r_wp == AW'(MAX_WINDOW - 1)) ? '0 : r_wp + 1'b1;
                r_fill <= fill_inc;
            end
            if (out_load) begin
                r_out_valid <= 1'b1;
            end else if (m_axis_tready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    // Datapath registers.
    always_ff @(posedge i_clk) begin
        case (r_state)
            ST_IDLE: begin
                r_n    <= n_eff;
                r_idx  <= n_eff;
                r_den  <= DW'(n_eff) * DW'(n_eff - 1'b1);
                r_time <= s_axis_tdata[PRICE_W +: TIME_W];
                r_rp   <= r_wp;
                r_sum  <= '0;
                r_sq   <= '0;
            end
            ST_RD_MUL: begin
                r_prod <= ram_rdata * ram_rdata;
                r_sum  <= r_sum + SW'(ram_rdata);
            end
            ST_RD_ACC: begin
                r_sq   <= r_sq + QW'(r_prod);
                r_idx  <= r_idx - 1'b1;
                r_rp   <= (r_rp == '0) ? AW'(MAX_WINDOW - 1) : r_rp - 1'b1;
                r_acc    <= '0;
                r_mplier <= SW'(r_n);
                r_mcnt   <= MCW'(SW);
            end
            ST_MUL_NQ: begin
                if (mul_last) begin
                    r_nq     <= mul_next;
                    r_acc    <= '0;
                    r_mplier <= r_sum;
                    r_mcnt   <= MCW'(SW);
                end else begin
                    r_acc    <= mul_next;
                    r_mplier <= {r_mplier[SW-2:0], 1'b0};
                    r_mcnt   <= r_mcnt - 1'b1;
                end
            end
            ST_MUL_SS: begin
                if (!mul_last) begin
                    r_mplier <= {r_mplier[SW-2:0], 1'b0};
                    r_mcnt   <= r_mcnt - 1'b1;
                end
                if (r_mcnt != '0) begin
                    r_acc <= mul_next;
                end
            end
            ST_DIV_MEAN: begin
                if (div_done) begin
                    r_mean <= div_quo[PRICE_W-1:0];
                end
            end
            ST_DIV_VAR: begin
                if (div_done) begin
                    r_var  <= (div_quo[VW-1:VARW] != '0) ? {VARW{1'b1}}
                                                         : div_quo[VARW-1:0];
                    r_rem  <= '0;
                    r_root <= '0;
                    r_scnt <= SCW'(PRICE_W);
                end
            end
            ST_SQRT: begin
                r_var  <= {r_var[VARW-3:0], 2'b00};
                r_scnt <= r_scnt - 1'b1;
                if (sq_ge) begin
                    r_rem  <= PRICE_W'(0) + (PRICE_W+1)'(rem_sh - trial);
                    r_root <= {r_root[PRICE_W-2:0], 1'b1};
                end else begin
                    r_rem  <= rem_sh[PRICE_W:0];
                    r_root <= {r_root[PRICE_W-2:0], 1'b0};
                end
            end
            ST_OUT: begin
                if (out_load) begin
                    r_out_data <= {1'b0, r_time, lower_band, upper_band, r_mean};
                end
            end
            default: begin
                r_mcnt <= r_mcnt;
            end
        endcase
    end

    assign m_axis_tvalid = r_out_valid;
    assign m_axis_tdata  = r_out_data;

endmodule

### hdl/bbc_checker.sv
// Port-level assertions for the Bollinger band calculator, bound to the top.
// Standalone; no package dependency.
module bbc_checker (
    input logic                      i_clk,
    input logic                      i_rst_n,
    input logic                      s_axis_tready,
    input logic                      m_axis_tvalid,
    input logic                      m_axis_tready,
    input logic [159:0]              m_axis_tdata
);

    // A pending result holds its value until the transaction completes.
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid && $stable(m_axis_tdata))
        else $error("output changed while stalled");

    // Reset drops any pending result.
    a_rst_clear: assert property (@(posedge i_clk)
        !i_rst_n |=> !m_axis_tvalid)
        else $error("output valid after reset");

    // Bands bracket the mean.
    a_band_order: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid |-> (m_axis_tdata[95:64] <= m_axis_tdata[31:0]) &&
                          (m_axis_tdata[31:0] <= m_axis_tdata[63:32]))
        else $error("band ordering violated");

    // A result appears only after a busy interval of the sequencer.
    a_new_result: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(m_axis_tvalid) |-> $past(!s_axis_tready))
        else $error("result without computation");

endmodule

bind bollinger_band_calculator_core bbc_checker u_bbc_checker (.*);

### dv/tb_bollinger_band_calculator_core.sv
// Testbench for the Bollinger band calculator core: drives price transactions,
// predicts mean and two-sigma bands per window, and checks every result.
// Depends on bbc_pkg and bollinger_band_calculator_core.
`timescale 1ns / 100ps

module tb_bollinger_band_calculator_core;
    import bbc_pkg::*;

    localparam int WIN_MAX   = MAX_WINDOW_DEF;
    localparam int IDLE_WAIT = 600;
    localparam int STALL_LIM = 40000;
    localparam logic [CFG_W-1:0] WIN_LENS [8] =
        '{7'd0, 7'd1, 7'd2, 7'd64, 7'd127, 7'd3, 7'd65, 7'd9};

    typedef struct packed {
        logic [TIME_W-1:0]  bar_time;
        logic [PRICE_W-1:0] close_price;
    } t_bar;

    typedef struct packed {
        logic [TIME_W-1:0]  result_time;
        logic [PRICE_W-1:0] lower_band;
        logic [PRICE_W-1:0] upper_band;
        logic [PRICE_W-1:0] middle_band;
    } t_bands;

    logic               i_clk = 1'b0;
    logic               i_rst_n = 1'b0;
    logic               i_cfg_we = 1'b0;
    logic [CFG_W-1:0]   i_cfg_wdata = '0;
    logic               s_axis_tvalid = 1'b0;
    logic               s_axis_tready;
    logic [95:0]        s_axis_tdata = '0;
    logic               m_axis_tvalid;
    logic               m_axis_tready = 1'b0;
    logic [159:0]       m_axis_tdata;

    bollinger_band_calculator_core i_dut (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_cfg_we      (i_cfg_we),
        .i_cfg_wdata   (i_cfg_wdata),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata)
    );

    always begin
        #2 i_clk = 1'b1;
        #2 i_clk = 1'b0;
    end

    // Predictor state.
    logic [CFG_W-1:0]   win_len_reg = WLEN_RESET;
    logic [PRICE_W-1:0] price_hist [WIN_MAX];
    int                 hist_count = 0;
    int                 hist_wr = 0;

    t_bar   pending_bars[$];
    t_bands band_queue[$];
    int     error_count = 0;
    int     result_count = 0;
    bit     gaps_on = 1'b1;
    bit     hold_rx = 1'b0;
    int     hold_cycles = 0;

    function automatic logic [63:0] int_sqrt(logic [63:0] v);
        logic [63:0] res;
        logic [63:0] bitv;
        res = 0;
        bitv = 64'd1 << 62;
        while (bitv > v) bitv >>= 2;
        while (bitv != 0) begin
            if (v >= res + bitv) begin
                v = v - (res + bitv);
                res = (res >> 1) + bitv;
            end else begin
                res >>= 1;
            end
            bitv >>= 2;
        end
        return res;
    endfunction

    // Updates the window with one bar and queues its bands once enough prices exist.
    task automatic predict_bands(t_bar b);
        int          n;
        logic [127:0] sum_p;
        logic [127:0] sum_sq;
        logic [127:0] var_w;
        logic [63:0]  var_c;
        logic [63:0]  sigma;
        logic [63:0]  mean;
        logic [63:0]  upper;
        logic [PRICE_W-1:0] p;
        t_bands r;
        price_hist[hist_wr] = b.close_price;
        hist_wr = (hist_wr + 1) % WIN_MAX;
        if (hist_count < WIN_MAX) hist_count++;
        n = win_len_reg;
        if (n < WIN_MIN) n = WIN_MIN;
        if (n > WIN_MAX) n = WIN_MAX;
        if (hist_count < n) return;
        sum_p = 0;
        sum_sq = 0;
        for (int i = 0; i < n; i++) begin
            p = price_hist[(hist_wr + WIN_MAX - 1 - i) % WIN_MAX];
            sum_p += p;
            sum_sq += 128'(p) * p;
        end
        mean = 64'((sum_p + n / 2) / n);
        var_w = (sum_sq * n - sum_p * sum_p) / (n * (n - 1));
        var_c = (var_w[127:64] != 0) ? '1 : var_w[63:0];
        sigma = int_sqrt(var_c);
        upper = mean + 2 * sigma;
        r.middle_band = mean[31:0];
        r.upper_band  = (upper > 64'hFFFF_FFFF) ? '1 : upper[31:0];
        r.lower_band  = (2 * sigma >= mean) ? '0 : 32'(mean - 2 * sigma);
        r.result_time = b.bar_time;
        band_queue = {band_queue, r};
    endtask

    function automatic t_bar rand_bar(int mode);
        t_bar b;
        b.bar_time = 63'({$urandom, $urandom});
        case (mode)
            0: b.close_price = $urandom;
            1: b.close_price = 32'h0064_0000 + $urandom_range(0, 32'h0004_0000);
            2: b.close_price = $urandom_range(32'hFFF0_0000, 32'hFFFF_FFFF);
            default: b.close_price = $urandom_range(0, 16);
        endcase
        return b;
    endfunction

    // Input transactions are seen at the rising edge, before the design moves on.
    bit in_taken = 1'b0;
    always @(posedge i_clk) begin
        in_taken = 1'b0;
        if (i_rst_n && s_axis_tvalid && s_axis_tready) begin
            predict_bands(t_bar'(s_axis_tdata[94:0]));
            void'(pending_bars.pop_front());
            in_taken = 1'b1;
        end
    end

    // Driver: presents queued bars, with random gaps.
    int tx_gap = 0;
    always @(negedge i_clk) begin
        if (i_rst_n) begin
            if (s_axis_tvalid && !in_taken) begin
                // Offer stays put until taken.
            end else if (tx_gap > 0) begin
                tx_gap <= tx_gap - 1;
                s_axis_tvalid <= 1'b0;
            end else if (gaps_on && $urandom_range(0, 9) == 0) begin
                tx_gap <= $urandom_range(0, 7);
                s_axis_tvalid <= 1'b0;
            end else if (pending_bars.size() > 0) begin
                s_axis_tvalid <= 1'b1;
                s_axis_tdata  <= {1'b0, pending_bars[0]};
            end else begin
                s_axis_tvalid <= 1'b0;
            end
        end
    end

    // Receiver ready, with random stalls and a long hold-off on request.
    int rx_gap = 0;
    always @(negedge i_clk) begin
        if (hold_rx) begin
            hold_rx = 1'b0;
            hold_cycles <= 8000;
            m_axis_tready <= 1'b0;
        end else if (hold_cycles > 0) begin
            hold_cycles <= hold_cycles - 1;
            m_axis_tready <= 1'b0;
        end else if (rx_gap > 0) begin
            rx_gap <= rx_gap - 1;
            m_axis_tready <= 1'b0;
        end else if (gaps_on && $urandom_range(0, 9) == 0) begin
            rx_gap <= $urandom_range(0, 7);
            m_axis_tready <= 1'b0;
        end else begin
            m_axis_tready <= 1'b1;
        end
    end

    // Monitor: compares each accepted result with the oldest prediction.
    t_bands got_bands;
    t_bands want_bands;
    always @(posedge i_clk) begin
        if (i_rst_n && m_axis_tvalid && m_axis_tready) begin
            got_bands = t_bands'(m_axis_tdata[158:0]);
            result_count++;
            if (band_queue.size() == 0) begin
                $display("%0t: result expected none actual %h", $realtime, got_bands);
                error_count++;
            end else begin
                want_bands = band_queue.pop_front();
                if (got_bands.middle_band !== want_bands.middle_band) begin
                    $display("%0t: middle_band expected %h actual %h", $realtime,
                             want_bands.middle_band, got_bands.middle_band);
                    error_count++;
                end
                if (got_bands.upper_band !== want_bands.upper_band) begin
                    $display("%0t: upper_band expected %h actual %h", $realtime,
                             want_bands.upper_band, got_bands.upper_band);
                    error_count++;
                end
                if (got_bands.lower_band !== want_bands.lower_band) begin
                    $display("%0t: lower_band expected %h actual %h", $realtime,
                             want_bands.lower_band, got_bands.lower_band);
                    error_count++;
                end
                if (got_bands.result_time !== want_bands.result_time) begin
                    $display("%0t: result_time expected %h actual %h", $realtime,
                             want_bands.result_time, got_bands.result_time);
                    error_count++;
                end
            end
        end
    end

    // Watchdog on cycles with no transaction on either side.
    int quiet_cycles = 0;
    always @(posedge i_clk) begin
        if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready))
            quiet_cycles <= 0;
        else
            quiet_cycles <= quiet_cycles + 1;
        if (quiet_cycles > STALL_LIM) begin
            $display("end of test: mismatches");
            $finish;
        end
    end

    task automatic wait_drained();
        while (pending_bars.size() > 0 || s_axis_tvalid || band_queue.size() > 0)
            @(posedge i_clk);
        repeat (IDLE_WAIT) @(posedge i_clk);
    endtask

    task automatic set_window(logic [CFG_W-1:0] len);
        @(negedge i_clk);
        i_cfg_we    <= 1'b1;
        i_cfg_wdata <= len;
        @(negedge i_clk);
        i_cfg_we    <= 1'b0;
        win_len_reg = len;
    endtask

    initial begin
        t_bar b;
        repeat (10) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;

        // Directed: reset length of 20, extreme prices and times.
        b.close_price = '0;           b.bar_time = '0;   pending_bars = {pending_bars, b};
        b.close_price = '1;           b.bar_time = '1;   pending_bars = {pending_bars, b};
        for (int i = 0; i < 20; i++) begin
            b.close_price = i[0] ? '1 : '0;
            b.bar_time = 63'({$urandom, $urandom});
            pending_bars = {pending_bars, b};
        end
        b.close_price = 32'h0001_0000; b.bar_time = 63'h2AAA_AAAA_AAAA_AAAA;
        pending_bars = {pending_bars, b};
        wait_drained();

        // Long receiver hold-off so the block backs up.
        set_window(7'd2);
        hold_rx = 1'b1;
        for (int i = 0; i < 30; i++) pending_bars = {pending_bars, rand_bar(0)};
        wait_drained();

        for (int ph = 0; ph < 8; ph++) begin
            set_window(WIN_LENS[ph]);
            for (int i = 0; i < 190; i++)
                pending_bars = {pending_bars, rand_bar($urandom_range(0, 3))};
            wait_drained();
        end
        // Final stretch without random gaps; window changes between drained runs.
        gaps_on = 1'b0;
        set_window(7'd64);
        for (int i = 0; i < 60; i++) pending_bars = {pending_bars, rand_bar(2)};
        wait_drained();
        set_window(7'd5);
        for (int i = 0; i < 40; i++) pending_bars = {pending_bars, rand_bar(1)};
        wait_drained();

        if (error_count == 0)
            $display("end of test: clean");
        else
            $display("end of test: mismatches");
        $finish;
    end

endmodule
